// ----- src/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int SlotCntDef = 8;
  localparam int CfgAddrW   = 3;
  localparam int CfgW       = 4;

  localparam logic [CfgAddrW-1:0] REG_TASKS_IN_USE = 3'd0;

  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_ENABLE       = 3'd1;
  localparam logic [2:0] OP_DISABLE      = 3'd2;
  localparam logic [2:0] OP_FORWARD      = 3'd3;
  localparam logic [2:0] OP_SET_INTERVAL = 3'd4;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  task_index;
    logic [31:0] now_time;
    logic [31:0] new_interval;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] fired_index;
    logic       task_enabled;
    logic       last_of_run;
  } rsp_t;

endpackage

// ----- src/periodic_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core
// Periodic task table with a tick scan and enable/disable/forward/interval ops.
// A status request gives its result in the cycle after acceptance and never
// sets busy. A tick walks the slots in use in S_RD and S_CHK (one memory read
// and one add/compare per task on the shared unit), then S_FIN; if none, it stays idle.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears the task table, the slot count and the sequencer.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_core
  import pts_pkg::*;
#(
  parameter int SLOT_CNT = SlotCntDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  req_t                req_i,
  output logic                res_valid_o,
  output rsp_t                res_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o
);

  localparam int IW = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
  localparam int CW = $clog2(SLOT_CNT + 1);
  localparam int SW = (CW > CfgW) ? CW : CfgW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          st_q, st_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       cnt_nxt;
  logic [31:0]         now_q, now_d;
  logic                pend_vld_q, pend_vld_d;
  logic [2:0]          pend_idx_q, pend_idx_d;
  logic                res_vld_q, res_vld_d;
  rsp_t                res_q, res_d;
  logic [SLOT_CNT-1:0] en_q, en_d;
  logic [CfgW-1:0]     cfg_q, cfg_d;

  logic [SW-1:0]       n_act;
  logic                idx_ok;
  logic [IW-1:0]       op_addr;
  logic [IW-1:0]       scan_addr;
  logic                accept;
  logic                cfg_wr;
  logic [31:0]         due;
  logic                fire;

  logic                int_we;
  logic                last_we;
  logic [IW-1:0]       waddr;
  logic [31:0]         wdata;
  logic [31:0]         rd_int;
  logic [31:0]         rd_last;

  pts_store #(
    .SLOT_CNT (SLOT_CNT)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .int_we_i   (int_we),
    .last_we_i  (last_we),
    .waddr_i    (waddr),
    .wdata_i    (wdata),
    .raddr_i    (scan_addr),
    .interval_o (rd_int),
    .last_o     (rd_last)
  );

  assign n_act     = (SW'(cfg_q) > SW'(SLOT_CNT)) ? SW'(SLOT_CNT) : SW'(cfg_q);
  assign idx_ok    = SW'(req_i.task_index) < n_act;
  assign op_addr   = IW'(req_i.task_index);
  assign scan_addr = cnt_q[IW-1:0];
  assign cnt_nxt   = cnt_q + 1'b1;
  assign accept    = start_i && (st_q == S_IDLE);
  assign busy_o    = st_q != S_IDLE;
  assign due       = rd_int + rd_last;
  assign fire      = en_q[scan_addr] && (now_q >= due);

  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign cfg_d    = (cfg_wr && paddr_i == REG_TASKS_IN_USE) ? pwdata_i[CfgW-1:0] : cfg_q;
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == REG_TASKS_IN_USE) ? 32'(cfg_q) : '0;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    en_d       = en_q;
    int_we     = 1'b0;
    last_we    = 1'b0;
    waddr      = op_addr;
    wdata      = req_i.new_interval;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.op)
            OP_TICK: begin
              now_d      = req_i.now_time;
              cnt_d      = '0;
              pend_vld_d = 1'b0;
              if (n_act != '0) begin
                st_d = S_RD;
              end
            end
            OP_ENABLE, OP_DISABLE, OP_FORWARD, OP_SET_INTERVAL: begin
              res_vld_d = 1'b1;
              if (!idx_ok) begin
                res_d = '{kind: KIND_RANGE, fired_index: req_i.task_index,
                          task_enabled: 1'b0, last_of_run: 1'b1};
              end else begin
                res_d = '{kind: KIND_DONE, fired_index: req_i.task_index,
                          task_enabled: en_q[op_addr], last_of_run: 1'b1};
                case (req_i.op)
                  OP_ENABLE: begin
                    en_d[op_addr]      = 1'b1;
                    last_we            = 1'b1;
                    wdata              = '0;
                    res_d.task_enabled = 1'b1;
                  end
                  OP_DISABLE: begin
                    en_d[op_addr]      = 1'b0;
                    res_d.task_enabled = 1'b0;
                  end
                  OP_FORWARD: begin
                    last_we = 1'b1;
                    wdata   = req_i.now_time;
                  end
                  default: begin
                    int_we = 1'b1;
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        st_d = S_CHK;
      end
      S_CHK: begin
        if (fire) begin
          last_we = 1'b1;
          waddr   = scan_addr;
          wdata   = now_q;
          if (pend_vld_q) begin
            res_vld_d = 1'b1;
            res_d     = '{kind: KIND_FIRED, fired_index: pend_idx_q,
                          task_enabled: 1'b1, last_of_run: 1'b0};
          end
          pend_vld_d = 1'b1;
          pend_idx_d = 3'(cnt_q);
        end
        if (SW'(cnt_nxt) == n_act) begin
          st_d = S_FIN;
        end else begin
          cnt_d = cnt_nxt;
          st_d  = S_RD;
        end
      end
      S_FIN: begin
        if (pend_vld_q) begin
          res_vld_d = 1'b1;
          res_d     = '{kind: KIND_FIRED, fired_index: pend_idx_q,
                        task_enabled: 1'b1, last_of_run: 1'b1};
        end
        pend_vld_d = 1'b0;
        st_d       = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      en_q       <= '0;
      cfg_q      <= '0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
      en_q       <= en_d;
      cfg_q      <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ----- src/pts_store.sv -----
// ----------------------------------------------------------------------------
// pts_store
// Interval and last-fired memories with one write and one registered read
// port each; entries never written read as zero.
// ----------------------------------------------------------------------------
module pts_store #(
  parameter int SLOT_CNT = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  int_we_i,
  input  logic                  last_we_i,
  input  logic [((SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1)-1:0] waddr_i,
  input  logic [31:0]           wdata_i,
  input  logic [((SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1)-1:0] raddr_i,
  output logic [31:0]           interval_o,
  output logic [31:0]           last_o
);

  logic [31:0]         int_mem [SLOT_CNT];
  logic [31:0]         last_mem [SLOT_CNT];
  logic [SLOT_CNT-1:0] int_vld_q;
  logic [SLOT_CNT-1:0] last_vld_q;
  logic [31:0]         int_rd_q;
  logic [31:0]         last_rd_q;
  logic                int_rd_vld_q;
  logic                last_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (int_we_i) begin
      int_mem[waddr_i] <= wdata_i;
    end
    if (last_we_i) begin
      last_mem[waddr_i] <= wdata_i;
    end
    int_rd_q  <= int_mem[raddr_i];
    last_rd_q <= last_mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_vld_q     <= '0;
      last_vld_q    <= '0;
      int_rd_vld_q  <= 1'b0;
      last_rd_vld_q <= 1'b0;
    end else begin
      if (int_we_i) begin
        int_vld_q[waddr_i] <= 1'b1;
      end
      if (last_we_i) begin
        last_vld_q[waddr_i] <= 1'b1;
      end
      int_rd_vld_q  <= int_vld_q[raddr_i];
      last_rd_vld_q <= last_vld_q[raddr_i];
    end
  end

  assign interval_o = int_rd_vld_q  ? int_rd_q  : '0;
  assign last_o     = last_rd_vld_q ? last_rd_q : '0;

endmodule

// ----- src/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks on the periodic task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker
  import pts_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic res_valid_o,
  input rsp_t res_o
);

  logic acc;
  logic stat_op;
  logic bad_op;

  assign acc     = start_i && !busy_o;
  assign stat_op = (req_i.op == OP_ENABLE) || (req_i.op == OP_DISABLE) ||
                   (req_i.op == OP_FORWARD) || (req_i.op == OP_SET_INTERVAL);
  assign bad_op  = (req_i.op != OP_TICK) && !stat_op;

  a_status_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && stat_op |=> res_valid_o && res_o.last_of_run &&
      (res_o.kind != KIND_FIRED) && (res_o.fired_index == $past(req_i.task_index)))
    else $error("status request did not return its result");

  a_bad_op_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && bad_op |=> !res_valid_o)
    else $error("unknown op returned a result");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.kind == KIND_FIRED) || (res_o.kind == KIND_DONE) ||
      (res_o.kind == KIND_RANGE))
    else $error("illegal result kind");

  a_fired_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_FIRED) |-> res_o.task_enabled)
    else $error("fired task reported disabled");

  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_RANGE) |-> !res_o.task_enabled && res_o.last_of_run)
    else $error("range error result malformed");

endmodule

bind periodic_task_scheduler_core pts_checker u_pts_checker (.*);

// ----- tb/periodic_task_scheduler_core_tb.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core_tb
// Self-checking bench for the periodic task scheduler. A directed table of
// requests and slot-count writes runs first, then random request streams over
// several slot counts. Every accepted request is run through a local schedule
// model; each strobed result is checked against the oldest predicted one.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_core_tb;
  import pts_pkg::*;

  localparam int TABLE_DEPTH     = SlotCntDef;
  localparam int SETTLE_CYCLES   = 2 * TABLE_DEPTH + 8;
  localparam int ITEMS_PER_PHASE = 24;
  localparam int DRAIN_LIMIT     = 5000;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    bit         set_slots;
    logic [3:0] slots;
    req_t       req;
    bit         typed;
    bit         has_res;
    rsp_t       res;
  } step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  req_t                req_i;
  logic                res_valid_o;
  rsp_t                res_o;
  logic                psel_i;
  logic                penable_i;
  logic                pwrite_i;
  logic [CfgAddrW-1:0] paddr_i;
  logic [31:0]         pwdata_i;
  logic [31:0]         prdata_o;
  logic                pready_o;

  logic        sched_enable     [TABLE_DEPTH];
  logic [31:0] sched_interval   [TABLE_DEPTH];
  logic [31:0] sched_last_fired [TABLE_DEPTH];
  logic [3:0]  sched_slots;

  rsp_t  run_results[$];
  rsp_t  pending_results[$];
  step_t directed_steps[$];
  int    mismatch_count = 0;
  rsp_t  want_res;

  periodic_task_scheduler_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int active_slots();
    return (sched_slots > TABLE_DEPTH) ? TABLE_DEPTH : int'(sched_slots);
  endfunction

  function automatic string fmt_rsp(rsp_t r);
    return $sformatf("kind %0d idx %0d en %0b last %0b",
                     r.kind, r.fired_index, r.task_enabled, r.last_of_run);
  endfunction

  function automatic void project_schedule(input req_t r);
    int          n;
    logic [31:0] due;
    rsp_t        res;
    run_results = {};
    n = active_slots();
    if (r.op == OP_TICK) begin
      for (int i = 0; i < n; i++) begin
        due = sched_last_fired[i] + sched_interval[i];
        if (sched_enable[i] && r.now_time >= due) begin
          res.kind         = KIND_FIRED;
          res.fired_index  = 3'(i);
          res.task_enabled = 1'b1;
          res.last_of_run  = 1'b0;
          run_results.push_back(res);
          sched_last_fired[i] = r.now_time;
        end
      end
      if (run_results.size() > 0) begin
        res = run_results.pop_back();
        res.last_of_run = 1'b1;
        run_results.push_back(res);
      end
    end else if (r.op <= OP_SET_INTERVAL) begin
      res.fired_index = r.task_index;
      res.last_of_run = 1'b1;
      if (r.task_index >= n) begin
        res.kind         = KIND_RANGE;
        res.task_enabled = 1'b0;
      end else begin
        case (r.op)
          OP_ENABLE: begin
            sched_enable[r.task_index]     = 1'b1;
            sched_last_fired[r.task_index] = '0;
          end
          OP_DISABLE: begin
            sched_enable[r.task_index] = 1'b0;
          end
          OP_FORWARD: begin
            sched_last_fired[r.task_index] = r.now_time;
          end
          default: begin
            sched_interval[r.task_index] = r.new_interval;
          end
        endcase
        res.kind         = KIND_DONE;
        res.task_enabled = sched_enable[r.task_index];
      end
      run_results.push_back(res);
    end
  endfunction

  function automatic step_t req_row(logic [2:0] op, logic [2:0] idx,
                                    logic [31:0] now, logic [31:0] ival);
    step_t s;
    s = '0;
    s.req.op           = op;
    s.req.task_index   = idx;
    s.req.now_time     = now;
    s.req.new_interval = ival;
    return s;
  endfunction

  function automatic step_t typed_row(logic [2:0] op, logic [2:0] idx,
                                      logic [31:0] now, logic [31:0] ival,
                                      bit has_res, logic [1:0] kind, logic en);
    step_t s;
    s = req_row(op, idx, now, ival);
    s.typed                = 1'b1;
    s.has_res              = has_res;
    s.res.kind             = kind;
    s.res.fired_index      = idx;
    s.res.task_enabled     = en;
    s.res.last_of_run      = 1'b1;
    return s;
  endfunction

  function automatic step_t slots_row(logic [3:0] n);
    step_t s;
    s = '0;
    s.set_slots = 1'b1;
    s.slots     = n;
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic issue_request(input req_t r, input bit typed, input bit has_res,
                               input rsp_t typed_res);
    req_i   <= r;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    project_schedule(r);
    if (typed) begin
      if (has_res) begin
        pending_results.push_back(typed_res);
      end
    end else begin
      foreach (run_results[k]) begin
        pending_results.push_back(run_results[k]);
      end
    end
  endtask

  task automatic settle_and_program(input logic [3:0] n);
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= REG_TASKS_IN_USE;
    pwdata_i  <= {28'b0, n};
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (pready_o !== 1'b1);
    sched_slots = n;
    pwrite_i  <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (pready_o !== 1'b1);
    if (prdata_o !== {28'b0, n}) begin
      note_mismatch($sformatf("slot count readback: expected %0d, got %h", n, prdata_o));
    end
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none pending: %s", fmt_rsp(res_o)));
      end else begin
        want_res = pending_results.pop_front();
        if (res_o.kind !== want_res.kind || res_o.fired_index !== want_res.fired_index ||
            res_o.task_enabled !== want_res.task_enabled ||
            res_o.last_of_run !== want_res.last_of_run) begin
          note_mismatch($sformatf("expected %s, got %s", fmt_rsp(want_res), fmt_rsp(res_o)));
        end
      end
    end
  end

  initial begin
    int          phase_slots[8];
    int          counted;
    int          roll;
    int          eff;
    logic [31:0] clock_ms;
    req_t        r;

    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    req_i     <= '0;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    paddr_i   <= '0;
    pwdata_i  <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sched_enable[i]     = 1'b0;
      sched_interval[i]   = '0;
      sched_last_fired[i] = '0;
    end
    sched_slots = '0;

    directed_steps.push_back(typed_row(OP_ENABLE, 3'd0, '0, '0, 1, KIND_RANGE, 1'b0));
    directed_steps.push_back(typed_row(OP_TICK, 3'd0, '1, '0, 0, KIND_DONE, 1'b0));
    directed_steps.push_back(typed_row(OP_UNUSED_HI, 3'd7, '1, '1, 0, KIND_DONE, 1'b0));
    directed_steps.push_back(slots_row(4'd8));
    directed_steps.push_back(typed_row(OP_SET_INTERVAL, 3'd7, '0, '1, 1, KIND_DONE, 1'b0));
    directed_steps.push_back(typed_row(OP_ENABLE, 3'd0, '0, '0, 1, KIND_DONE, 1'b1));
    directed_steps.push_back(typed_row(OP_ENABLE, 3'd7, '0, '0, 1, KIND_DONE, 1'b1));
    directed_steps.push_back(req_row(OP_TICK, 3'd0, '0, '0));
    directed_steps.push_back(req_row(OP_TICK, 3'd0, '1, '0));
    directed_steps.push_back(typed_row(OP_FORWARD, 3'd7, 32'd1, '0, 1, KIND_DONE, 1'b1));
    directed_steps.push_back(req_row(OP_TICK, 3'd0, '0, '0));
    directed_steps.push_back(typed_row(OP_DISABLE, 3'd0, '0, '0, 1, KIND_DONE, 1'b0));
    directed_steps.push_back(typed_row(OP_SET_INTERVAL, 3'd7, '0, '0, 1, KIND_DONE, 1'b1));
    for (int i = 1; i < 7; i++) begin
      directed_steps.push_back(req_row(OP_ENABLE, 3'(i), '0, '0));
    end
    directed_steps.push_back(typed_row(OP_ENABLE, 3'd0, '0, '0, 1, KIND_DONE, 1'b1));
    directed_steps.push_back(req_row(OP_TICK, 3'd0, 32'd5, '0));
    directed_steps.push_back(typed_row(OP_UNUSED_LO, 3'd0, '0, '0, 0, KIND_DONE, 1'b0));
    directed_steps.push_back(slots_row(4'd3));
    directed_steps.push_back(typed_row(OP_DISABLE, 3'd3, '0, '0, 1, KIND_RANGE, 1'b0));
    directed_steps.push_back(typed_row(OP_FORWARD, 3'd7, '1, '0, 1, KIND_RANGE, 1'b0));
    directed_steps.push_back(typed_row(OP_SET_INTERVAL, 3'd5, '0, '1, 1, KIND_RANGE, 1'b0));
    directed_steps.push_back(req_row(OP_TICK, 3'd0, 32'd1000, '0));
    directed_steps.push_back(slots_row(4'd12));
    directed_steps.push_back(typed_row(OP_DISABLE, 3'd7, '0, '0, 1, KIND_DONE, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].set_slots) begin
        settle_and_program(directed_steps[k].slots);
      end else begin
        issue_request(directed_steps[k].req, directed_steps[k].typed,
                      directed_steps[k].has_res, directed_steps[k].res);
        if ($urandom_range(0, 3) == 0) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    phase_slots = '{8, 1, $urandom_range(1, 8), 0, $urandom_range(1, 8), 15,
                    $urandom_range(1, 8), 8};
    clock_ms = $urandom_range(0, 1000);
    foreach (phase_slots[p]) begin
      settle_and_program(4'(phase_slots[p]));
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        eff  = active_slots();
        roll = $urandom_range(0, 99);
        if (roll < 35) r.op = OP_TICK;
        else if (roll < 50) r.op = OP_ENABLE;
        else if (roll < 60) r.op = OP_DISABLE;
        else if (roll < 75) r.op = OP_FORWARD;
        else if (roll < 95) r.op = OP_SET_INTERVAL;
        else r.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (eff > 0 && $urandom_range(0, 9) < 8) begin
          r.task_index = 3'($urandom_range(0, eff - 1));
        end else begin
          r.task_index = 3'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 49) == 0) begin
          clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
        end
        if ($urandom_range(0, 4) == 0) begin
          r.now_time = $urandom;
        end else begin
          clock_ms   = clock_ms + $urandom_range(0, 24);
          r.now_time = clock_ms;
        end
        case ($urandom_range(0, 6))
          0:       r.new_interval = $urandom;
          1:       r.new_interval = '1;
          2:       r.new_interval = '0;
          default: r.new_interval = $urandom_range(0, 40);
        endcase
        if (r.op <= OP_SET_INTERVAL) counted++;
        issue_request(r, 1'b0, 1'b0, '0);
        if (p != 7 && $urandom_range(0, 3) == 0) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    start_i <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    foreach (pending_results[k]) begin
      note_mismatch($sformatf("result never arrived: %s", fmt_rsp(pending_results[k])));
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
